### hdl/srr_pkg.sv
// Shared constants for the sequence-numbered replay ring.
// Field widths, command codes and parameter defaults; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

  localparam int CMD_W     = 2;
  localparam int SEQ_W     = 48;
  localparam int LEN_W     = 8;
  localparam int PAYLOAD_W = 64;
  localparam int CNT_OUT_W = 11;

  localparam int DEPTH_DEF        = 1024;
  localparam int PAYLOAD_BITS_DEF = 64;

  // Counter saturates here; a put is refused once next sequence reaches it.
  localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRUNC  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STATUS = 2'd3;

endpackage

`default_nettype wire

### hdl/srr_slot_ram.sv
// Slot memory of the replay ring: one write port, one registered read port.
// Generic; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srr_slot_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 169
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/srr_locate.sv
// Window check and slot lookup for a get: slot is found relative to the put slot.
// Uses srr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module srr_locate #(
  parameter int DEPTH = 1024
) (
  input  wire logic [srr_pkg::SEQ_W-1:0]  next_seq,
  input  wire logic [$clog2(DEPTH)-1:0]   put_slot,
  input  wire logic [srr_pkg::SEQ_W-1:0]  seq,
  output logic                            in_window,
  output logic      [$clog2(DEPTH)-1:0]   slot
);
  import srr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0]    DEPTH_C = CW'(DEPTH);
  localparam logic [SEQ_W-1:0] DEPTH_S = SEQ_W'(DEPTH);

  logic [SEQ_W-1:0] gap;
  logic [CW-1:0]    gap_l;
  logic [CW-1:0]    ps;
  logic [CW-1:0]    diff;

  // gap in 1..DEPTH when the sequence is inside the window
  assign gap       = next_seq - seq;
  assign in_window = (seq != '0) && (seq < next_seq) && (gap <= DEPTH_S);
  assign gap_l     = gap[CW-1:0];
  assign ps        = CW'(put_slot);

  always_comb begin
    if (ps >= gap_l) begin
      diff = ps - gap_l;
    end else begin
      diff = ps + (DEPTH_C - gap_l);
    end
  end

  assign slot = diff[AW-1:0];

endmodule

`default_nettype wire

### hdl/sequence_numbered_replay_ring.sv
// Sequence-numbered replay ring, top level: command sequencer around the slot memory.
// Depends on srr_pkg, srr_slot_ram and srr_locate.
//
// After reset the block runs a clearing pass over every slot of the memory,
// with busy high; commands are taken once busy drops. A command is accepted when
// start is high and busy is low. For a put or status query the result shows in
// the next cycle and another command can be accepted in that cycle. A get reads
// the slot memory through its registered read port, and the result is registered
// in S_GET from the read data. Truncate walks every slot through the single memory
// read port, one slot per cycle, and writes back the slots it invalidates. Every
// result is on the out_ ports for exactly one cycle, marked by out_strobe; the
// receiver cannot hold it off. out_stored_count, out_first_seq and out_last_seq
// reflect the state after the command.
`timescale 1ns / 1ps
`default_nettype none

module sequence_numbered_replay_ring #(
  parameter int DEPTH        = srr_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [srr_pkg::CMD_W-1:0]      in_command,
  input  wire logic [srr_pkg::SEQ_W-1:0]      in_seq_number,
  input  wire logic [srr_pkg::PAYLOAD_W-1:0]  in_payload,
  input  wire logic [srr_pkg::LEN_W-1:0]      in_length,
  input  wire logic [srr_pkg::SEQ_W-1:0]      in_now_time,
  output logic                                out_strobe,
  output logic                                out_status,
  output logic      [srr_pkg::SEQ_W-1:0]      out_seq_out,
  output logic      [srr_pkg::PAYLOAD_W-1:0]  out_payload_out,
  output logic      [srr_pkg::LEN_W-1:0]      out_length_out,
  output logic      [srr_pkg::SEQ_W-1:0]      out_stamp_out,
  output logic      [srr_pkg::CNT_OUT_W-1:0]  out_stored_count,
  output logic      [srr_pkg::SEQ_W-1:0]      out_first_seq,
  output logic      [srr_pkg::SEQ_W-1:0]      out_last_seq
);
  import srr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PB = PAYLOAD_BITS;
  // entry: valid | tag | length | stamp | payload
  localparam int EW       = 1 + SEQ_W + LEN_W + SEQ_W + PB;
  localparam int STAMP_LO = PB;
  localparam int LEN_LO   = PB + SEQ_W;
  localparam int TAG_LO   = PB + SEQ_W + LEN_W;
  localparam int V_BIT    = EW - 1;

  localparam logic [AW-1:0]    LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0]    DEPTH_C = CW'(DEPTH);
  localparam logic [SEQ_W-1:0] SEQ_ONE = SEQ_W'(1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_GET   = 2'd2;
  localparam logic [1:0] S_TRUNC = 2'd3;

  logic [1:0]       state_r,    state_nxt;
  logic [AW-1:0]    addr_r,     addr_nxt;
  logic [SEQ_W-1:0] next_seq_r, next_seq_nxt;
  logic [AW-1:0]    put_slot_r, put_slot_nxt;
  logic [CW-1:0]    count_r,    count_nxt;
  logic             strobe_r,   strobe_nxt;
  logic [SEQ_W-1:0] seq_q_r,    seq_q_nxt;
  logic             win_r,      win_nxt;
  logic             status_r,   status_nxt;
  logic [SEQ_W-1:0] seq_out_r,  seq_out_nxt;
  logic [PB-1:0]    pay_r,      pay_nxt;
  logic [LEN_W-1:0] len_r,      len_nxt;
  logic [SEQ_W-1:0] stamp_r,    stamp_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  logic          get_in_window;
  logic [AW-1:0] get_slot;

  logic             rd_valid;
  logic [SEQ_W-1:0] rd_tag;
  logic [LEN_W-1:0] rd_len;
  logic [SEQ_W-1:0] rd_stamp;
  logic [PB-1:0]    rd_pay;
  logic             put_ok;
  logic             get_hit;
  logic             trunc_hit;
  logic [SEQ_W-1:0] count_ext;

  srr_slot_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW),
    .DATA_W (EW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  srr_locate #(
    .DEPTH (DEPTH)
  ) u_locate (
    .next_seq  (next_seq_r),
    .put_slot  (put_slot_r),
    .seq       (in_seq_number),
    .in_window (get_in_window),
    .slot      (get_slot)
  );

  assign rd_valid = mem_rdata[V_BIT];
  assign rd_tag   = mem_rdata[TAG_LO +: SEQ_W];
  assign rd_len   = mem_rdata[LEN_LO +: LEN_W];
  assign rd_stamp = mem_rdata[STAMP_LO +: SEQ_W];
  assign rd_pay   = mem_rdata[PB-1:0];

  assign put_ok    = (in_length != '0) && (next_seq_r != SEQ_MAX);
  assign get_hit   = win_r && rd_valid && (rd_tag == seq_q_r);
  assign trunc_hit = rd_valid && (rd_tag < seq_q_r) && (rd_tag < next_seq_r);

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    next_seq_nxt = next_seq_r;
    put_slot_nxt = put_slot_r;
    count_nxt    = count_r;
    strobe_nxt   = 1'b0;
    seq_q_nxt    = seq_q_r;
    win_nxt      = win_r;
    status_nxt   = status_r;
    seq_out_nxt  = seq_out_r;
    pay_nxt      = pay_r;
    len_nxt      = len_r;
    stamp_nxt    = stamp_r;
    mem_we       = 1'b0;
    mem_waddr    = addr_r;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = addr_r + 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == LAST_A) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          seq_q_nxt = in_seq_number;
          win_nxt   = get_in_window;
          unique case (in_command)
            CMD_PUT: begin
              strobe_nxt = 1'b1;
              pay_nxt    = '0;
              len_nxt    = '0;
              stamp_nxt  = '0;
              if (put_ok) begin
                mem_we       = 1'b1;
                mem_waddr    = put_slot_r;
                mem_wdata    = {1'b1, next_seq_r, in_length, in_now_time, in_payload[PB-1:0]};
                status_nxt   = 1'b0;
                seq_out_nxt  = next_seq_r;
                next_seq_nxt = next_seq_r + SEQ_ONE;
                put_slot_nxt = (put_slot_r == LAST_A) ? '0 : put_slot_r + 1'b1;
                if (count_r < DEPTH_C) begin
                  count_nxt = count_r + 1'b1;
                end
              end else begin
                status_nxt  = 1'b1;
                seq_out_nxt = '0;
              end
            end
            CMD_GET: begin
              mem_re    = 1'b1;
              mem_raddr = get_slot;
              state_nxt = S_GET;
            end
            CMD_TRUNC: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              addr_nxt  = '0;
              state_nxt = S_TRUNC;
            end
            CMD_STATUS: begin
              strobe_nxt  = 1'b1;
              status_nxt  = 1'b0;
              seq_out_nxt = '0;
              pay_nxt     = '0;
              len_nxt     = '0;
              stamp_nxt   = '0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_GET: begin
        strobe_nxt  = 1'b1;
        status_nxt  = ~get_hit;
        seq_out_nxt = get_hit ? seq_q_r : '0;
        pay_nxt     = get_hit ? rd_pay : '0;
        len_nxt     = get_hit ? rd_len : '0;
        stamp_nxt   = get_hit ? rd_stamp : '0;
        state_nxt   = S_IDLE;
      end

      S_TRUNC: begin
        // read data belongs to addr_r; next slot is read while this one is written back
        if (trunc_hit) begin
          mem_we    = 1'b1;
          mem_waddr = addr_r;
          mem_wdata = {1'b0, mem_rdata[EW-2:0]};
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end
        if (addr_r == LAST_A) begin
          strobe_nxt  = 1'b1;
          status_nxt  = 1'b0;
          seq_out_nxt = '0;
          pay_nxt     = '0;
          len_nxt     = '0;
          stamp_nxt   = '0;
          addr_nxt    = '0;
          state_nxt   = S_IDLE;
        end else begin
          mem_re   = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      addr_r     <= '0;
      next_seq_r <= SEQ_ONE;
      put_slot_r <= '0;
      count_r    <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      next_seq_r <= next_seq_nxt;
      put_slot_r <= put_slot_nxt;
      count_r    <= count_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_q_r   <= seq_q_nxt;
    win_r     <= win_nxt;
    status_r  <= status_nxt;
    seq_out_r <= seq_out_nxt;
    pay_r     <= pay_nxt;
    len_r     <= len_nxt;
    stamp_r   <= stamp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign count_ext = SEQ_W'(count_r);

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_seq_out      = seq_out_r;
  assign out_payload_out  = PAYLOAD_W'(pay_r);
  assign out_length_out   = len_r;
  assign out_stamp_out    = stamp_r;
  assign out_stored_count = CNT_OUT_W'(count_r);
  assign out_first_seq    = (next_seq_r > count_ext) ? (next_seq_r - count_ext) : SEQ_ONE;
  assign out_last_seq     = next_seq_r - SEQ_ONE;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("held count above depth");

  a_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_seq_r != '0)
    else $error("next sequence reached zero");

  a_ok_seq_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && !status_r) |-> (seq_out_r < next_seq_r))
    else $error("reported sequence not yet assigned");

  a_trunc_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRUNC && addr_r == LAST_A) |=> (strobe_r && state_r == S_IDLE))
    else $error("truncate sweep did not finish with a result");

  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GET) |=> strobe_r)
    else $error("get produced no result");

endmodule

`default_nettype wire

### tb/srr_ring_checker.sv
// Scoreboard for the sequence-numbered replay ring: watches command and result ports,
// keeps its own copy of the ring and checks every result field in order.
// Depends on srr_pkg.
`timescale 1ns / 1ps

module srr_ring_checker #(
  parameter int DEPTH        = srr_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [srr_pkg::CMD_W-1:0]      in_command,
  input  logic [srr_pkg::SEQ_W-1:0]      in_seq_number,
  input  logic [srr_pkg::PAYLOAD_W-1:0]  in_payload,
  input  logic [srr_pkg::LEN_W-1:0]      in_length,
  input  logic [srr_pkg::SEQ_W-1:0]      in_now_time,
  input  logic                           out_strobe,
  input  logic                           out_status,
  input  logic [srr_pkg::SEQ_W-1:0]      out_seq_out,
  input  logic [srr_pkg::PAYLOAD_W-1:0]  out_payload_out,
  input  logic [srr_pkg::LEN_W-1:0]      out_length_out,
  input  logic [srr_pkg::SEQ_W-1:0]      out_stamp_out,
  input  logic [srr_pkg::CNT_OUT_W-1:0]  out_stored_count,
  input  logic [srr_pkg::SEQ_W-1:0]      out_first_seq,
  input  logic [srr_pkg::SEQ_W-1:0]      out_last_seq,
  output int                             fail_count,
  output int                             pending,
  output int                             checked,
  output int                             get_hits
);
  import srr_pkg::*;

  typedef struct packed {
    logic                 status;
    logic [SEQ_W-1:0]     seq;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     len;
    logic [SEQ_W-1:0]     stamp;
    logic [CNT_OUT_W-1:0] count;
    logic [SEQ_W-1:0]     first;
    logic [SEQ_W-1:0]     last;
  } ring_result_t;

  // mirror of the slot memory
  logic [SEQ_W-1:0]     tag_mem     [DEPTH];
  logic [PAYLOAD_W-1:0] payload_mem [DEPTH];
  logic [LEN_W-1:0]     len_mem     [DEPTH];
  logic [SEQ_W-1:0]     stamp_mem   [DEPTH];
  bit                   valid_mem   [DEPTH];
  logic [SEQ_W-1:0]     next_seq;
  int unsigned          held;

  ring_result_t expected_q[$];

  function automatic int slot_of(input logic [SEQ_W-1:0] seq);
    logic [SEQ_W-1:0] idx;
    idx = (seq - 48'd1) % DEPTH;
    return int'(idx);
  endfunction

  function automatic ring_result_t step_ring(input logic [CMD_W-1:0] cmd,
                                             input logic [SEQ_W-1:0] seq,
                                             input logic [PAYLOAD_W-1:0] data,
                                             input logic [LEN_W-1:0] len,
                                             input logic [SEQ_W-1:0] now);
    ring_result_t         res;
    int                   slot;
    logic [SEQ_W-1:0]     oldest;
    logic [PAYLOAD_W-1:0] mask;
    res  = '0;
    mask = (PAYLOAD_BITS >= 64) ? {PAYLOAD_W{1'b1}} : ((64'd1 << PAYLOAD_BITS) - 64'd1);
    case (cmd)
      CMD_PUT: begin
        if (len == '0 || next_seq >= SEQ_MAX) begin
          res.status = 1'b1;
        end else begin
          slot = slot_of(next_seq);
          tag_mem[slot]     = next_seq;
          payload_mem[slot] = data & mask;
          len_mem[slot]     = len;
          stamp_mem[slot]   = now;
          valid_mem[slot]   = 1'b1;
          res.seq  = next_seq;
          next_seq = next_seq + 48'd1;
          if (held < DEPTH) held++;
        end
      end
      CMD_GET: begin
        oldest = (next_seq > DEPTH) ? next_seq - DEPTH : 48'd1;
        res.status = 1'b1;
        if (seq != '0 && seq < next_seq && seq >= oldest) begin
          slot = slot_of(seq);
          if (valid_mem[slot] && tag_mem[slot] == seq) begin
            res.status  = 1'b0;
            res.seq     = seq;
            res.payload = payload_mem[slot];
            res.len     = len_mem[slot];
            res.stamp   = stamp_mem[slot];
          end
        end
      end
      CMD_TRUNC: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (valid_mem[i] && tag_mem[i] < seq && tag_mem[i] < next_seq) begin
            valid_mem[i] = 1'b0;
            if (held > 0) held--;
          end
        end
      end
      default: ;
    endcase
    res.count = held[CNT_OUT_W-1:0];
    res.first = (next_seq > held) ? next_seq - held : 48'd1;
    res.last  = next_seq - 48'd1;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    get_hits   = 0;
  end

  always @(posedge clk) begin
    ring_result_t want;
    ring_result_t res;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) valid_mem[i] = 1'b0;
      next_seq = 48'd1;
      held     = 0;
      expected_q.delete();
    end else begin
      // retire the result first: it belongs to an item accepted earlier
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("seq_out", 64'(want.seq), 64'(out_seq_out));
          check_field("payload_out", want.payload, out_payload_out);
          check_field("length_out", 64'(want.len), 64'(out_length_out));
          check_field("stamp_out", 64'(want.stamp), 64'(out_stamp_out));
          check_field("stored_count", 64'(want.count), 64'(out_stored_count));
          check_field("first_seq", 64'(want.first), 64'(out_first_seq));
          check_field("last_seq", 64'(want.last), 64'(out_last_seq));
          checked++;
        end
      end
      if (start && !busy) begin
        res = step_ring(in_command, in_seq_number, in_payload, in_length, in_now_time);
        if (in_command == CMD_GET && !res.status) get_hits++;
        expected_q.push_back(res);
      end
    end
    pending = expected_q.size();
  end

endmodule

### tb/sequence_numbered_replay_ring_tb.sv
// Top of the replay ring testbench: clock, reset, directed and random command stimulus.
// Depends on srr_pkg, the sequence_numbered_replay_ring RTL and srr_ring_checker.
`timescale 1ns / 1ps

module sequence_numbered_replay_ring_tb;
  import srr_pkg::*;

  localparam int DEPTH     = DEPTH_DEF;
  localparam int N_RANDOM  = 1430;
  localparam int CALM_TAIL = 200;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     in_command;
  logic [SEQ_W-1:0]     in_seq_number;
  logic [PAYLOAD_W-1:0] in_payload;
  logic [LEN_W-1:0]     in_length;
  logic [SEQ_W-1:0]     in_now_time;
  logic                 out_strobe;
  logic                 out_status;
  logic [SEQ_W-1:0]     out_seq_out;
  logic [PAYLOAD_W-1:0] out_payload_out;
  logic [LEN_W-1:0]     out_length_out;
  logic [SEQ_W-1:0]     out_stamp_out;
  logic [CNT_OUT_W-1:0] out_stored_count;
  logic [SEQ_W-1:0]     out_first_seq;
  logic [SEQ_W-1:0]     out_last_seq;

  int fail_count, pending, checked, get_hits;
  int n_put, n_get, n_trunc, n_query;
  logic [SEQ_W-1:0] next_free_seq;  // sequence the next good put will get

  sequence_numbered_replay_ring #(.DEPTH(DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS_DEF)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_seq_number(in_seq_number), .in_payload(in_payload),
    .in_length(in_length), .in_now_time(in_now_time),
    .out_strobe(out_strobe), .out_status(out_status), .out_seq_out(out_seq_out),
    .out_payload_out(out_payload_out), .out_length_out(out_length_out),
    .out_stamp_out(out_stamp_out), .out_stored_count(out_stored_count),
    .out_first_seq(out_first_seq), .out_last_seq(out_last_seq)
  );

  srr_ring_checker #(.DEPTH(DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS_DEF)) ring_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_seq_number(in_seq_number), .in_payload(in_payload),
    .in_length(in_length), .in_now_time(in_now_time),
    .out_strobe(out_strobe), .out_status(out_status), .out_seq_out(out_seq_out),
    .out_payload_out(out_payload_out), .out_length_out(out_length_out),
    .out_stamp_out(out_stamp_out), .out_stored_count(out_stored_count),
    .out_first_seq(out_first_seq), .out_last_seq(out_last_seq),
    .fail_count(fail_count), .pending(pending), .checked(checked), .get_hits(get_hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [SEQ_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[SEQ_W-1:0];
  endfunction

  function automatic logic [PAYLOAD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SEQ_W-1:0] window_oldest();
    return (next_free_seq > DEPTH) ? next_free_seq - DEPTH : 48'd1;
  endfunction

  function automatic logic [LEN_W-1:0] rand_length();
    if ($urandom_range(0, 39) == 0) return '0;
    return LEN_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [SEQ_W-1:0] pick_get_seq();
    int unsigned      r;
    int unsigned      span;
    logic [SEQ_W-1:0] oldest;
    r      = $urandom_range(0, 99);
    oldest = window_oldest();
    span   = int'(next_free_seq - oldest);
    if (r < 60 && span > 0) return next_free_seq - 48'd1 - $urandom_range(0, span - 1);
    if (r < 70) return oldest - $urandom_range(0, 1);
    if (r < 76) return '0;
    if (r < 86) return next_free_seq + $urandom_range(0, 2);
    if (r < 95) return rand48();
    return SEQ_MAX - $urandom_range(0, 1);
  endfunction

  function automatic logic [SEQ_W-1:0] pick_trunc_bound();
    int unsigned      r;
    int unsigned      span;
    logic [SEQ_W-1:0] oldest;
    r      = $urandom_range(0, 99);
    oldest = window_oldest();
    span   = int'(next_free_seq - oldest);
    if (r < 55) return oldest + $urandom_range(0, 48);
    if (r < 75) return oldest + $urandom_range(0, span);
    if (r < 85) return SEQ_W'($urandom_range(0, 1));
    if (r < 95) return next_free_seq + $urandom_range(0, 3);
    return rand48();
  endfunction

  // hold start high from the next falling edge until the item is taken
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                      input logic [PAYLOAD_W-1:0] data, input logic [LEN_W-1:0] len,
                      input logic [SEQ_W-1:0] now);
    @(negedge clk);
    start         <= 1'b1;
    in_command    <= cmd;
    in_seq_number <= seq;
    in_payload    <= data;
    in_length     <= len;
    in_now_time   <= now;
    do @(posedge clk); while (busy);
    case (cmd)
      CMD_PUT: begin
        n_put++;
        if (len != '0) next_free_seq = next_free_seq + 48'd1;
      end
      CMD_GET:   n_get++;
      CMD_TRUNC: n_trunc++;
      default:   n_query++;
    endcase
  endtask

  // start low for the given cycles, with junk on the fields
  task automatic idle(input int cycles);
    @(negedge clk);
    start         <= 1'b0;
    in_command    <= CMD_W'($urandom);
    in_seq_number <= rand48();
    in_payload    <= rand64();
    in_length     <= LEN_W'($urandom);
    in_now_time   <= rand48();
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    idle(1);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned r;
    bit          calm;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CMD_STATUS;
    in_seq_number = '0;
    in_payload    = '0;
    in_length     = '0;
    in_now_time   = '0;
    next_free_seq = 48'd1;
    n_put = 0; n_get = 0; n_trunc = 0; n_query = 0;
    calm = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // empty ring first
    send(CMD_STATUS, '0, '0, '0, '0);
    send(CMD_GET, '0, '0, '0, '0);
    send(CMD_GET, 48'd1, '0, '0, '0);
    send(CMD_TRUNC, SEQ_MAX, '0, '0, '0);
    send(CMD_PUT, '0, rand64(), '0, rand48());             // zero length is refused
    send(CMD_PUT, SEQ_MAX, '0, 8'd1, '0);
    send(CMD_PUT, '0, {PAYLOAD_W{1'b1}}, 8'hFF, SEQ_MAX);
    send(CMD_PUT, rand48(), 64'hA5A5_5A5A_F00D_0FF0, 8'h80, 48'h0000_8000_0001);
    send(CMD_GET, 48'd1, '0, '0, '0);
    send(CMD_GET, 48'd2, '0, '0, '0);
    send(CMD_GET, 48'd3, '0, '0, '0);
    send(CMD_GET, 48'd4, '0, '0, '0);                      // just past the last sequence
    send(CMD_GET, SEQ_MAX, '0, '0, '0);
    send(CMD_TRUNC, 48'd2, '0, '0, '0);                    // drops sequence 1 only
    send(CMD_GET, 48'd1, '0, '0, '0);
    send(CMD_GET, 48'd2, '0, '0, '0);
    send(CMD_STATUS, SEQ_MAX, {PAYLOAD_W{1'b1}}, 8'hFF, SEQ_MAX);
    send(CMD_TRUNC, '0, '0, '0, '0);                       // bound zero drops nothing
    send(CMD_PUT, '0, 64'h1, 8'h7F, 48'h1);
    send(CMD_GET, 48'd4, '0, '0, '0);
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 78)
        send(CMD_PUT, rand48(), rand64(), rand_length(), rand48());
      else if (r < 92)
        send(CMD_GET, pick_get_seq(), rand64(), LEN_W'($urandom), rand48());
      else if (r < 96)
        send(CMD_TRUNC, pick_trunc_bound(), rand64(), LEN_W'($urandom), rand48());
      else
        send(CMD_STATUS, rand48(), rand64(), LEN_W'($urandom), rand48());
      if (n == N_RANDOM / 2)
        drain();
      else if (!calm && n < N_RANDOM - CALM_TAIL && $urandom_range(0, 5) == 0)
        idle($urandom_range(1, 6));
    end

    drain();
    repeat (DEPTH + 8) @(negedge clk);
    $display("Sent %0d put, %0d get, %0d truncate and %0d query items; last sequence %0d.",
             n_put, n_get, n_trunc, n_query, next_free_seq - 48'd1);
    $display("Checked %0d results; %0d gets returned a stored entry.", checked, get_hits);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
